>>> rtl/lpf_pkg.sv
package lpf_pkg;

    // Screen geometry.
    localparam int SCREEN_COLUMNS = 40;
    localparam int SCREEN_ROWS    = 28;

    localparam int COL_W   = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
    localparam int ROW_W   = $clog2(SCREEN_ROWS);
    // Signed width that holds any position plus any extent minus one.
    localparam int COORD_W = 10;

    // Panel stream layout.
    localparam logic [7:0] STREAM_MARKER     = 8'hFF;
    localparam logic [7:0] STREAM_FINAL      = 8'd160;
    localparam int         STREAM_SLOTS      = 80;
    localparam int         STREAM_HALF_SLOTS = 40;
    localparam int         STREAM_LAST_ROW   = 27;
    localparam int         STREAM_FAR_OFFSET = 13;
    localparam int         STREAM_BITS       = 7;

    typedef enum logic [2:0] {
        CMD_SET     = 3'd0,
        CMD_READ    = 3'd1,
        CMD_FILL    = 3'd2,
        CMD_OUTLINE = 3'd3,
        CMD_SCAN    = 3'd4
    } cmd_t;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    typedef enum logic [1:0] {
        TASK_DRAW,
        TASK_READ,
        TASK_SCAN
    } task_op_t;

    typedef logic [SCREEN_ROWS-1:0] col_word_t;

    typedef struct packed {
        logic [2:0]        command;
        logic              pixel_on;
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
        logic [6:0]        rect_width;
        logic [6:0]        rect_height;
    } in_word_t;

    typedef struct packed {
        logic       result_kind;
        logic       read_value;
        logic [7:0] scan_byte;
        logic       frame_last;
    } out_word_t;

    // Classified command as it travels from the front to the back.
    typedef struct packed {
        task_op_t                  op;
        logic                      fill;
        logic                      val;
        logic                      hit;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col_lo;
        logic [COL_W-1:0]          col_hi;
        logic signed [COORD_W-1:0] side_a;
        logic signed [COORD_W-1:0] side_b;
        col_word_t                 hmask;
        col_word_t                 vmask;
    } task_t;

endpackage

>>> rtl/led_panel_framebuffer_scanout.sv
// One-bit frame store of 40 columns by 28 rows with a panel stream scan-out.
//
// Command channel (cmd_valid/cmd_ready/cmd_word): one word per command: set
// pixel, read pixel, fill rectangle, outline rectangle or scan step. Result
// channel (res_valid/res_ready/res_word): one word for each read and each scan
// step; drawing commands and unused command codes give no word.
//
// A two-entry queue takes command words while the back end works. A read or
// scan result passes from the queue through the current-task register, the
// memory read stage and the output register. The back end takes a new task
// only when done with the last; a fill or outline walks each clipped column it
// covers in turn through the single read-modify-write port of the column memory.
//
// Reset clears the per-column valid flags, so the whole image reads as off at
// once, and puts the stream at its marker byte. When the receiver holds
// res_ready low, the finished word waits in the output register, the next
// result stalls behind it, and cmd_ready drops once the queue is full.
module led_panel_framebuffer_scanout (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  lpf_pkg::in_word_t  cmd_word,
    output logic               res_valid,
    input  logic               res_ready,
    output lpf_pkg::out_word_t res_word
);

    logic           task_valid;
    logic           task_ready;
    lpf_pkg::task_t task_word;

    // Front end: classify commands into column walks and queue them.
    lpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_word   (cmd_word),
        .task_valid (task_valid),
        .task_ready (task_ready),
        .task_word  (task_word)
    );

    // Back end: walks the column memory and produces result words.
    lpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (task_valid),
        .task_ready (task_ready),
        .task_word  (task_word),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_word   (res_word)
    );

    // A read answer carries nothing in the scan fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_word.result_kind == lpf_pkg::KIND_READ) |->
            (res_word.scan_byte == 8'd0) && !res_word.frame_last)
        else $error("read answer with scan fields set");

    // A scan word never carries a read value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_word.result_kind == lpf_pkg::KIND_SCAN) |-> !res_word.read_value)
        else $error("scan word with read value set");

    // The end-of-frame flag only comes with a scan word.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.frame_last |-> (res_word.result_kind == lpf_pkg::KIND_SCAN))
        else $error("frame end flag on a read answer");

    // Back-pressure on commands only happens with work waiting in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> task_valid)
        else $error("command channel stalled with an empty queue");

endmodule

>>> rtl/lpf_front.sv
module lpf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  lpf_pkg::in_word_t cmd_word,
    output logic             task_valid,
    input  logic             task_ready,
    output lpf_pkg::task_t   task_word
);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [lpf_pkg::COORD_W-1:0] C_ZERO = '0;
    localparam logic signed [lpf_pkg::COORD_W-1:0] C_ONE  = lpf_pkg::COORD_W'(1);
    localparam logic signed [lpf_pkg::COORD_W-1:0] C_LAST_COL =
        lpf_pkg::COORD_W'(lpf_pkg::SCREEN_COLUMNS - 1);
    localparam logic signed [lpf_pkg::COORD_W-1:0] C_LAST_ROW =
        lpf_pkg::COORD_W'(lpf_pkg::SCREEN_ROWS - 1);

    // Rows lo..hi inclusive, as a column mask; empty when hi < lo.
    function automatic lpf_pkg::col_word_t row_span(
        input logic signed [lpf_pkg::COORD_W-1:0] lo,
        input logic signed [lpf_pkg::COORD_W-1:0] hi
    );
        lpf_pkg::col_word_t                    m;
        logic signed [lpf_pkg::COORD_W-1:0]    rr;
        m = '0;
        for (int r = 0; r < lpf_pkg::SCREEN_ROWS; r++)
        begin
            rr   = lpf_pkg::COORD_W'(r);
            m[r] = (rr >= lo) && (rr <= hi);
        end
        return m;
    endfunction

    lpf_pkg::task_t queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    lpf_pkg::task_t t;
    logic push;
    logic is_draw;
    logic enq;
    logic deq;
    logic signed [lpf_pkg::COORD_W-1:0] x, y, w, h, x_far, y_far, lo, hi, lo_c, hi_c;

    always_comb
    begin
        x     = {{(lpf_pkg::COORD_W-8){cmd_word.pos_x[7]}}, cmd_word.pos_x};
        y     = {{(lpf_pkg::COORD_W-8){cmd_word.pos_y[7]}}, cmd_word.pos_y};
        w     = lpf_pkg::COORD_W'(cmd_word.rect_width);
        h     = lpf_pkg::COORD_W'(cmd_word.rect_height);
        x_far = x + w - C_ONE;
        y_far = y + h - C_ONE;

        t       = '0;
        t.val   = cmd_word.pixel_on;
        push    = 1'b0;
        is_draw = 1'b0;
        lo      = x;
        hi      = x;

        case (cmd_word.command)
            lpf_pkg::CMD_SET:
            begin
                is_draw = 1'b1;
                t.op    = lpf_pkg::TASK_DRAW;
                t.fill  = 1'b1;
                t.vmask = row_span(y, y);
            end
            lpf_pkg::CMD_FILL:
            begin
                is_draw = 1'b1;
                t.op    = lpf_pkg::TASK_DRAW;
                t.fill  = 1'b1;
                t.vmask = row_span(y, y_far);
                hi      = x_far;
            end
            lpf_pkg::CMD_OUTLINE:
            begin
                // A zero width still draws the sides at x and x-1.
                is_draw  = 1'b1;
                t.op     = lpf_pkg::TASK_DRAW;
                t.fill   = 1'b0;
                t.side_a = x;
                t.side_b = x_far;
                t.vmask  = row_span(y, y_far);
                t.hmask  = (w != C_ZERO) ? (row_span(y, y) | row_span(y_far, y_far)) : '0;
                lo       = (w == C_ZERO) ? x - C_ONE : x;
                hi       = (w == C_ZERO) ? x : x_far;
            end
            lpf_pkg::CMD_READ:
            begin
                push     = 1'b1;
                t.op     = lpf_pkg::TASK_READ;
                t.hit    = (x >= C_ZERO) && (x <= C_LAST_COL) &&
                           (y >= C_ZERO) && (y <= C_LAST_ROW);
                t.row    = t.hit ? y[lpf_pkg::ROW_W-1:0] : '0;
                t.col_lo = t.hit ? x[lpf_pkg::COL_W-1:0] : '0;
                t.col_hi = t.col_lo;
            end
            lpf_pkg::CMD_SCAN:
            begin
                push = 1'b1;
                t.op = lpf_pkg::TASK_SCAN;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase

        // Clip the column walk to the screen; a walk that misses it is dropped.
        lo_c = (lo < C_ZERO) ? C_ZERO : lo;
        hi_c = (hi > C_LAST_COL) ? C_LAST_COL : hi;
        if (is_draw)
        begin
            push     = (lo_c <= hi_c);
            t.col_lo = lo_c[lpf_pkg::COL_W-1:0];
            t.col_hi = hi_c[lpf_pkg::COL_W-1:0];
        end
    end

    assign cmd_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign task_valid = (count_reg != '0);
    assign task_word  = queue_reg[rd_ptr_reg];
    assign enq        = cmd_valid && cmd_ready && push;
    assign deq        = task_valid && task_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (enq && !deq)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (deq && !enq)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            queue_reg[wr_ptr_reg] <= t;
        end
    end

endmodule

>>> rtl/lpf_back.sv
module lpf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               task_valid,
    output logic               task_ready,
    input  lpf_pkg::task_t     task_word,
    output logic               res_valid,
    input  logic               res_ready,
    output lpf_pkg::out_word_t res_word
);

    typedef struct packed {
        logic marker;
        logic bottom;
        logic half;
        logic last;
    } scan_t;

    typedef struct packed {
        lpf_pkg::task_op_t           op;
        logic                        val;
        logic                        hit;
        logic [lpf_pkg::ROW_W-1:0]   row;
        scan_t                       scan;
        lpf_pkg::col_word_t          mask;
        logic [lpf_pkg::COL_W-1:0]   col;
    } stage_t;

    // Seven stream bits out of one column word.
    function automatic logic [lpf_pkg::STREAM_BITS-1:0] pack_bits(
        input lpf_pkg::col_word_t word,
        input logic               bottom,
        input logic               half
    );
        logic [lpf_pkg::STREAM_BITS-1:0] b;
        b = '0;
        for (int j = 0; j < lpf_pkg::STREAM_BITS; j++)
        begin
            if (!bottom && !half)
            begin
                b[j] = word[j];
            end
            else if (!bottom)
            begin
                b[j] = word[lpf_pkg::STREAM_FAR_OFFSET - j];
            end
            else if (!half)
            begin
                b[j] = word[lpf_pkg::STREAM_LAST_ROW - j];
            end
            else
            begin
                b[j] = word[lpf_pkg::STREAM_LAST_ROW - lpf_pkg::STREAM_FAR_OFFSET + j];
            end
        end
        return b;
    endfunction

    lpf_pkg::col_word_t frame_mem [lpf_pkg::SCREEN_COLUMNS];
    logic [lpf_pkg::SCREEN_COLUMNS-1:0] col_valid_reg;

    logic                        act_reg;
    lpf_pkg::task_t              cur_reg;
    lpf_pkg::task_t              cur_next;
    scan_t                       scan_reg;
    logic [lpf_pkg::COL_W-1:0]   col_reg;
    logic [7:0]                  scan_pos_reg;
    logic [7:0]                  scan_pos_next;

    logic                        b_valid_reg;
    stage_t                      b_reg;
    lpf_pkg::col_word_t          rd_mem_reg;
    logic                        rd_vld_reg;

    logic                        res_valid_reg;
    lpf_pkg::out_word_t          res_reg;
    lpf_pkg::out_word_t          res_next;

    logic                        adv;
    logic                        issue;
    logic                        walk_done;
    logic                        b_result;
    logic                        wr_en;
    logic                        res_load;
    logic                        side_hit;
    stage_t                      stage_next;
    lpf_pkg::col_word_t          word;
    lpf_pkg::col_word_t          wr_data;

    logic [7:0]                  k;
    logic [6:0]                  slot;
    logic [6:0]                  scol;
    logic                        s_wrap;
    logic                        s_exists;
    scan_t                       scan_dec;

    // Stream position decode for the next scan step.
    always_comb
    begin
        s_wrap          = (scan_pos_reg == 8'd0) || (scan_pos_reg > lpf_pkg::STREAM_FINAL);
        k               = scan_pos_reg - 8'd1;
        slot            = k[7:1];
        scan_dec.half   = k[0];
        scan_dec.bottom = (slot >= 7'(lpf_pkg::STREAM_HALF_SLOTS));
        scol            = scan_dec.bottom ? (7'(lpf_pkg::STREAM_SLOTS - 1) - slot) : slot;
        s_exists        = (scol < 7'(lpf_pkg::SCREEN_COLUMNS));
        scan_dec.marker = s_wrap;
        scan_dec.last   = (scan_pos_reg == lpf_pkg::STREAM_FINAL);
        if (s_wrap)
        begin
            scan_pos_next = 8'd1;
        end
        else if (scan_dec.last)
        begin
            scan_pos_next = 8'd0;
        end
        else
        begin
            scan_pos_next = scan_pos_reg + 8'd1;
        end
    end

    // A scan step only hits the memory when its column exists.
    always_comb
    begin
        cur_next = task_word;
        if (task_word.op == lpf_pkg::TASK_SCAN)
        begin
            cur_next.hit = s_exists;
        end
    end

    // A result stage stalls only while the output register is still full.
    assign b_result   = b_valid_reg && (b_reg.op != lpf_pkg::TASK_DRAW);
    assign adv        = !(b_result && res_valid_reg && !res_ready);
    assign task_ready = !act_reg && adv;
    assign issue      = act_reg && adv;
    assign walk_done  = (cur_reg.op != lpf_pkg::TASK_DRAW) || (col_reg == cur_reg.col_hi);

    always_comb
    begin
        side_hit = (lpf_pkg::COORD_W'(col_reg) == cur_reg.side_a) ||
                   (lpf_pkg::COORD_W'(col_reg) == cur_reg.side_b);
        stage_next.op   = cur_reg.op;
        stage_next.val  = cur_reg.val;
        stage_next.hit  = cur_reg.hit;
        stage_next.row  = cur_reg.row;
        stage_next.scan = scan_reg;
        stage_next.col  = col_reg;
        stage_next.mask = cur_reg.fill ? cur_reg.vmask :
                          (cur_reg.hmask | (side_hit ? cur_reg.vmask : '0));
    end

    always_comb
    begin
        word     = rd_vld_reg ? rd_mem_reg : '0;
        wr_data  = (word & ~b_reg.mask) | (b_reg.val ? b_reg.mask : '0);
        wr_en    = adv && b_valid_reg && (b_reg.op == lpf_pkg::TASK_DRAW);
        res_load = adv && b_result;

        res_next = '0;
        if (b_reg.op == lpf_pkg::TASK_SCAN)
        begin
            res_next.result_kind = lpf_pkg::KIND_SCAN;
            res_next.frame_last  = b_reg.scan.last;
            if (b_reg.scan.marker)
            begin
                res_next.scan_byte = lpf_pkg::STREAM_MARKER;
            end
            else if (b_reg.hit)
            begin
                res_next.scan_byte = {1'b0, pack_bits(word, b_reg.scan.bottom, b_reg.scan.half)};
            end
        end
        else
        begin
            res_next.result_kind = lpf_pkg::KIND_READ;
            res_next.read_value  = b_reg.hit ? word[b_reg.row] : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            b_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            scan_pos_reg  <= '0;
            col_valid_reg <= '0;
        end
        else
        begin
            if (task_valid && task_ready)
            begin
                act_reg <= 1'b1;
                if (task_word.op == lpf_pkg::TASK_SCAN)
                begin
                    scan_pos_reg <= scan_pos_next;
                end
            end
            else if (issue && walk_done)
            begin
                act_reg <= 1'b0;
            end

            if (adv)
            begin
                b_valid_reg <= act_reg;
            end

            if (wr_en)
            begin
                col_valid_reg[b_reg.col] <= 1'b1;
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (task_valid && task_ready)
        begin
            cur_reg  <= cur_next;
            scan_reg <= scan_dec;
            if (task_word.op == lpf_pkg::TASK_SCAN)
            begin
                col_reg <= s_exists ? scol[lpf_pkg::COL_W-1:0] : '0;
            end
            else
            begin
                col_reg <= task_word.col_lo;
            end
        end
        else if (issue && !walk_done)
        begin
            col_reg <= col_reg + 1'b1;
        end

        if (issue)
        begin
            b_reg      <= stage_next;
            rd_mem_reg <= frame_mem[col_reg];
            rd_vld_reg <= col_valid_reg[col_reg];
        end

        if (wr_en)
        begin
            frame_mem[b_reg.col] <= wr_data;
        end

        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;

endmodule

>>> tb/sv/testbench.sv
module testbench;

    // Command codes 5 to 7 are not decoded by the block: it drops them without
    // a result word and without touching the image or the stream position.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    localparam int RANDOM_ITEMS  = 900;
    localparam int DIRECTED_ROWS = 25;
    localparam int MAX_GAP       = 19;
    // A fill or outline may keep the back end busy, column by column, after the
    // last result word has gone, so the run idles this long at the end.
    localparam int DRAIN_CYCLES  = 80;
    // The watchdog fires after this many cycles with no word accepted on either
    // channel. The longest correct quiet period is the receiver hold-off below.
    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AT_WORD  = 200;
    localparam int MAX_REPORTS   = 10;

    localparam lpf_pkg::out_word_t NO_ANSWER = '0;

    // One row of the directed table. Where has_answer is set, the result word
    // is typed in and replaces the predicted one. The prediction still runs so
    // that the image and the stream position stay in step with the block.
    typedef struct packed {
        lpf_pkg::in_word_t  word;
        logic               has_answer;
        lpf_pkg::out_word_t answer;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    lpf_pkg::in_word_t  cmd_word = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    lpf_pkg::out_word_t res_word;

    // Shadow copy of the frame store and of the stream position.
    lpf_pkg::col_word_t frame_cols [lpf_pkg::SCREEN_COLUMNS];
    int                 scan_idx;

    // Result words still owed by the block, oldest first.
    lpf_pkg::out_word_t awaited_words [$];

    stim_row_t directed_rows [DIRECTED_ROWS];

    int failures;
    int words_seen;
    int reads_seen;
    int scans_seen;
    int frames_seen;
    int idle_cycles;
    int cmd_count [8];

    led_panel_framebuffer_scanout u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow model of the block.
    // ------------------------------------------------------------------

    // Writes are clipped: anything off the screen is simply dropped.
    function automatic void paint(logic on, int x, int y);
        if (x < 0 || x >= lpf_pkg::SCREEN_COLUMNS || y < 0 || y >= lpf_pkg::SCREEN_ROWS)
            return;
        frame_cols[x][y] = on;
    endfunction

    function automatic logic pixel_at(int x, int y);
        if (x < 0 || x >= lpf_pkg::SCREEN_COLUMNS || y < 0 || y >= lpf_pkg::SCREEN_ROWS)
            return 1'b0;
        return frame_cols[x][y];
    endfunction

    // Stream bytes 1..160 are two bytes per column slot. The first 40 slots walk
    // the top half of columns 0..39; the next 40 walk the bottom half of columns
    // 39..0 counting rows up from the last one. The second byte of a slot takes
    // its seven rows in the reverse order, starting 13 rows in.
    function automatic logic [7:0] panel_byte(int idx);
        int         slot;
        int         half;
        int         col;
        int         row0;
        int         dir;
        int         step;
        logic [7:0] packed_px;
        slot = (idx - 1) >> 1;
        half = (idx - 1) & 1;
        col  = slot;
        row0 = 0;
        dir  = 1;
        packed_px = '0;
        if (slot >= lpf_pkg::STREAM_HALF_SLOTS)
        begin
            col  = lpf_pkg::STREAM_SLOTS - slot - 1;
            row0 = lpf_pkg::STREAM_LAST_ROW;
            dir  = -1;
        end
        for (int j = 0; j < lpf_pkg::STREAM_BITS; j++)
        begin
            step = half ? (lpf_pkg::STREAM_FAR_OFFSET - j) : j;
            packed_px[j] = pixel_at(col, row0 + step * dir);
        end
        return packed_px;
    endfunction

    function automatic lpf_pkg::out_word_t read_answer(logic value);
        lpf_pkg::out_word_t r;
        r = '0;
        r.result_kind = lpf_pkg::KIND_READ;
        r.read_value  = value;
        return r;
    endfunction

    function automatic lpf_pkg::out_word_t scan_answer(logic [7:0] b, logic last);
        lpf_pkg::out_word_t r;
        r = '0;
        r.result_kind = lpf_pkg::KIND_SCAN;
        r.scan_byte   = b;
        r.frame_last  = last;
        return r;
    endfunction

    // Applies one command to the shadow state and returns the word it causes.
    function automatic logic run_command(lpf_pkg::in_word_t w,
                                         output lpf_pkg::out_word_t res);
        int x;
        int y;
        int wd;
        int ht;
        logic [7:0] b;
        x  = w.pos_x;
        y  = w.pos_y;
        wd = w.rect_width;
        ht = w.rect_height;
        res = NO_ANSWER;
        case (w.command)
            lpf_pkg::CMD_SET:
            begin
                paint(w.pixel_on, x, y);
                return 1'b0;
            end
            lpf_pkg::CMD_READ:
            begin
                res = read_answer(pixel_at(x, y));
                return 1'b1;
            end
            lpf_pkg::CMD_FILL:
            begin
                for (int a = 0; a < wd; a++)
                    for (int c = 0; c < ht; c++)
                        paint(w.pixel_on, x + a, y + c);
                return 1'b0;
            end
            lpf_pkg::CMD_OUTLINE:
            begin
                // The edges are drawn as plain loops, so a zero extent puts the
                // far edge one row (or column) before the near one.
                for (int a = 0; a < wd; a++)
                begin
                    paint(w.pixel_on, x + a, y);
                    paint(w.pixel_on, x + a, y + ht - 1);
                end
                for (int c = 0; c < ht; c++)
                begin
                    paint(w.pixel_on, x, y + c);
                    paint(w.pixel_on, x + wd - 1, y + c);
                end
                return 1'b0;
            end
            lpf_pkg::CMD_SCAN:
            begin
                if (scan_idx == 0 || scan_idx > lpf_pkg::STREAM_FINAL)
                begin
                    scan_idx = 0;
                    b = lpf_pkg::STREAM_MARKER;
                end
                else
                begin
                    b = panel_byte(scan_idx);
                end
                res = scan_answer(b, scan_idx == lpf_pkg::STREAM_FINAL);
                scan_idx = (scan_idx == lpf_pkg::STREAM_FINAL) ? 0 : scan_idx + 1;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic lpf_pkg::in_word_t word_of(logic [2:0] code, logic on, int x, int y,
                                                  int wd, int ht);
        lpf_pkg::in_word_t v;
        v.command     = code;
        v.pixel_on    = on;
        v.pos_x       = x[7:0];
        v.pos_y       = y[7:0];
        v.rect_width  = wd[6:0];
        v.rect_height = ht[6:0];
        return v;
    endfunction

    // Random commands mostly land on or just around the screen with small
    // rectangles, which is where clipping and the image contents matter. Now
    // and then a field takes any value of its width.
    function automatic lpf_pkg::in_word_t random_word();
        lpf_pkg::in_word_t v;
        int                pick;
        logic [2:0]        code;
        pick = int'($urandom_range(0, 99));
        if (pick < 20)      code = lpf_pkg::CMD_SET;
        else if (pick < 40) code = lpf_pkg::CMD_READ;
        else if (pick < 51) code = lpf_pkg::CMD_FILL;
        else if (pick < 62) code = lpf_pkg::CMD_OUTLINE;
        else if (pick < 96) code = lpf_pkg::CMD_SCAN;
        else                code = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        v = word_of(code, 1'($urandom_range(0, 1)),
                    int'($urandom_range(0, lpf_pkg::SCREEN_COLUMNS + 5)) - 3,
                    int'($urandom_range(0, lpf_pkg::SCREEN_ROWS + 5)) - 3,
                    int'($urandom_range(0, 12)), int'($urandom_range(0, 12)));
        if ($urandom_range(0, 7) == 0) v.pos_x = 8'($urandom);
        if ($urandom_range(0, 7) == 0) v.pos_y = 8'($urandom);
        if ($urandom_range(0, 9) == 0) v.rect_width = 7'($urandom);
        if ($urandom_range(0, 9) == 0) v.rect_height = 7'($urandom);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Command side.
    // ------------------------------------------------------------------

    logic send_steady = 1'b0;

    // Offers one command word and returns at the edge where it is taken. Valid
    // stays high on return, so a back-to-back word never drops it; it only
    // falls when a gap is drawn for the next word.
    task automatic issue(lpf_pkg::in_word_t w, logic has_answer, lpf_pkg::out_word_t answer);
        int                 gap;
        lpf_pkg::out_word_t predicted;
        logic               gives_word;
        if ($urandom_range(0, 39) == 0)
            send_steady = ~send_steady;
        gap = send_steady ? 0 : int'($urandom_range(0, MAX_GAP));
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        cmd_count[w.command]++;
        gives_word = run_command(w, predicted);
        if (gives_word)
            awaited_words.push_back(has_answer ? answer : predicted);
    endtask

    // ------------------------------------------------------------------
    // Result side.
    // ------------------------------------------------------------------

    logic take_steady = 1'b0;

    initial
    begin : result_side
        int                 gap;
        lpf_pkg::out_word_t want;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_steady = ~take_steady;
            gap = take_steady ? 0 : int'($urandom_range(0, MAX_GAP));
            // One long hold-off lets the two-entry queue fill so that the block
            // must hold cmd_ready low while the command side keeps offering.
            if (words_seen == HOLD_AT_WORD)
                gap = LONG_HOLD;
            if (gap > 0)
            begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
            words_seen++;
            if (res_word.result_kind == lpf_pkg::KIND_SCAN) scans_seen++;
            else reads_seen++;
            if (res_word.result_kind == lpf_pkg::KIND_SCAN && res_word.frame_last)
                frames_seen++;
            if (awaited_words.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: result word %h arrived with none outstanding",
                             res_word);
            end
            else
            begin
                want = awaited_words.pop_front();
                if (res_word.result_kind !== want.result_kind ||
                    res_word.read_value  !== want.read_value  ||
                    res_word.scan_byte   !== want.scan_byte   ||
                    res_word.frame_last  !== want.frame_last)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display({"ERROR: result word %0d: expected kind %b read %b ",
                                  "byte %h last %b, got kind %b read %b byte %h last %b"},
                                 words_seen, want.result_kind, want.read_value,
                                 want.scan_byte, want.frame_last,
                                 res_word.result_kind, res_word.read_value,
                                 res_word.scan_byte, res_word.frame_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: quiet cycles on both channels at once.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ERROR: no word moved for %0d cycles, %0d results outstanding",
                         idle_cycles, awaited_words.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    initial
    begin : command_side
        int issued;
        int spare_count;
        failures    = 0;
        words_seen  = 0;
        reads_seen  = 0;
        scans_seen  = 0;
        frames_seen = 0;
        idle_cycles = 0;
        scan_idx    = 0;
        for (int c = 0; c < lpf_pkg::SCREEN_COLUMNS; c++) frame_cols[c] = '0;
        for (int k = 0; k < 8; k++) cmd_count[k] = 0;

        // The directed table: clear image reads, the marker after reset, pixels
        // at the corners, off-screen accesses on every side, a fill that covers
        // the whole screen from off it, empty fills, outlines with a zero
        // extent (which land one row or column before the start), an outline
        // with both extents zero, an outline entirely off the screen, and the
        // codes that the block ignores.
        directed_rows = '{
            '{word_of(lpf_pkg::CMD_READ, 1'b0, 0, 0, 0, 0), 1'b1, read_answer(1'b0)},
            '{word_of(lpf_pkg::CMD_SCAN, 1'b0, 0, 0, 0, 0), 1'b1,
              scan_answer(lpf_pkg::STREAM_MARKER, 1'b0)},
            '{word_of(lpf_pkg::CMD_SET, 1'b1, 0, 0, 0, 0), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_SET, 1'b1, 39, 27, 127, 127), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_READ, 1'b0, 0, 0, 0, 0), 1'b1, read_answer(1'b1)},
            '{word_of(lpf_pkg::CMD_READ, 1'b1, 39, 27, 0, 0), 1'b1, read_answer(1'b1)},
            '{word_of(lpf_pkg::CMD_READ, 1'b0, -128, -128, 0, 0), 1'b1, read_answer(1'b0)},
            '{word_of(lpf_pkg::CMD_READ, 1'b0, 127, 127, 127, 127), 1'b1, read_answer(1'b0)},
            '{word_of(lpf_pkg::CMD_READ, 1'b0, 40, 27, 0, 0), 1'b1, read_answer(1'b0)},
            '{word_of(lpf_pkg::CMD_READ, 1'b0, 39, 28, 0, 0), 1'b1, read_answer(1'b0)},
            '{word_of(lpf_pkg::CMD_SET, 1'b1, -1, 5, 0, 0), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_FILL, 1'b1, -5, -5, 127, 127), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_READ, 1'b0, 20, 14, 0, 0), 1'b1, read_answer(1'b1)},
            '{word_of(lpf_pkg::CMD_FILL, 1'b0, 10, 10, 0, 5), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_FILL, 1'b0, 10, 10, 5, 0), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_FILL, 1'b0, 3, 3, 10, 10), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_OUTLINE, 1'b0, 20, 2, 8, 6), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_OUTLINE, 1'b0, 25, 15, 6, 0), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_OUTLINE, 1'b0, 30, 15, 0, 6), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_OUTLINE, 1'b0, 0, 0, 0, 0), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_OUTLINE, 1'b1, -128, -128, 127, 127), 1'b0, NO_ANSWER},
            '{word_of(CMD_SPARE_FIRST, 1'b1, 4, 4, 9, 9), 1'b0, NO_ANSWER},
            '{word_of(CMD_SPARE_LAST, 1'b0, 0, 0, 127, 127), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_SCAN, 1'b0, 0, 0, 0, 0), 1'b0, NO_ANSWER},
            '{word_of(lpf_pkg::CMD_SCAN, 1'b1, -1, -1, 127, 127), 1'b0, NO_ANSWER}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue(directed_rows[i].word, directed_rows[i].has_answer,
                  directed_rows[i].answer);

        // Random part. Ignored codes are sent but not counted toward the total.
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            lpf_pkg::in_word_t w;
            w = random_word();
            // Halfway through, the command side goes quiet until every result
            // word owed so far has come back.
            if (issued == RANDOM_ITEMS / 2)
            begin
                cmd_valid <= 1'b0;
                do @(posedge clk); while (awaited_words.size() != 0);
            end
            issue(w, 1'b0, NO_ANSWER);
            if (w.command <= lpf_pkg::CMD_SCAN)
                issued++;
        end

        cmd_valid <= 1'b0;
        do @(posedge clk); while (awaited_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        failures += awaited_words.size();

        spare_count = 0;
        for (int k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++)
            spare_count += cmd_count[k];

        $display("Sent %0d sets, %0d reads, %0d fills, %0d outlines, %0d scans, %0d ignored",
                 cmd_count[lpf_pkg::CMD_SET], cmd_count[lpf_pkg::CMD_READ],
                 cmd_count[lpf_pkg::CMD_FILL], cmd_count[lpf_pkg::CMD_OUTLINE],
                 cmd_count[lpf_pkg::CMD_SCAN], spare_count);
        $display("Checked %0d read answers and %0d stream bytes over %0d full frames",
                 reads_seen, scans_seen, frames_seen);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
